// ----- sv/lmbs_pkg.sv -----
// ----------------------------------------------------------------------------
// LED matrix BCM scanner package
// Shared constants, item types and helper functions for the scanner.
// ----------------------------------------------------------------------------
package lmbs_pkg;

   // Panel geometry and modulation depth.
   localparam int COLUMNS    = 64;
   localparam int PANEL_ROWS = 32;
   localparam int PLANES     = 4;

   localparam int HALF_ROWS = PANEL_ROWS / 2;
   localparam int COL_W     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W     = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
   localparam int ADDR_W    = ROW_W + COL_W;

   // Fixed field widths of the scan state.
   localparam int SROW_W  = 4;
   localparam int PLANE_W = 2;
   localparam int DWELL_W = 3;
   localparam int PIX_W   = 12;

   // Item kinds.
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_SET  = 2'd1;
   localparam logic [1:0] KIND_FILL = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [5:0]        color_bits;
      logic [SROW_W-1:0] row_select;
      logic              latch_strobe;
      logic              last;
   } rsp_type;

   // Control of the two frame store halves for one cycle.
   typedef struct packed {
      logic              wr_top;
      logic              wr_bot;
      logic [ADDR_W-1:0] wr_addr;
      logic [PIX_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctl_type;

   // Pack the low nibble of each color: red low, blue high.
   function automatic logic [PIX_W-1:0] pack_color(input logic [7:0] r,
                                                   input logic [7:0] g,
                                                   input logic [7:0] b);
      return {b[3:0], g[3:0], r[3:0]};
   endfunction

   // Red, green and blue bits of one pixel at the given plane.
   function automatic logic [2:0] plane_bits(input logic [PIX_W-1:0]   pix,
                                             input logic [PLANE_W-1:0] plane);
      return {pix[8 + plane], pix[4 + plane], pix[plane]};
   endfunction

endpackage

// ----- sv/lmbs_frame_bank.sv -----
// ----------------------------------------------------------------------------
// LED matrix BCM scanner frame bank
// Frame store split into top and bottom half memories, registered reads.
// ----------------------------------------------------------------------------
module lmbs_frame_bank (
   input  logic                              clock,
   input  lmbs_pkg::ram_ctl_type             ctl,
   output logic [lmbs_pkg::PIX_W-1:0]        rd_top,
   output logic [lmbs_pkg::PIX_W-1:0]        rd_bot
);

   localparam int DEPTH = 1 << lmbs_pkg::ADDR_W;

   logic [lmbs_pkg::PIX_W-1:0] top_mem [DEPTH];
   logic [lmbs_pkg::PIX_W-1:0] bot_mem [DEPTH];
   logic [lmbs_pkg::PIX_W-1:0] rd_top_ff;
   logic [lmbs_pkg::PIX_W-1:0] rd_bot_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_top) begin
         top_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_top_ff <= top_mem[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_bot) begin
         bot_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_bot_ff <= bot_mem[ctl.rd_addr];
      end
   end

   // The read registers hold their value while no read is issued.
   assign rd_top = rd_top_ff;
   assign rd_bot = rd_bot_ff;

endmodule

// ----- sv/led_matrix_bcm_scanner_top.sv -----
// ----------------------------------------------------------------------------
// LED matrix BCM scanner
// Frame store and binary code modulation scan sequencer for a two-half panel.
// ----------------------------------------------------------------------------
// A refreshing tick passes through the state register, the read register and the
// output register before its first column word, then gives one word per cycle
// while the result side does not stall; the next item is not taken before the
// last word leaves the read stage. The single read port of each half memory sets
// this pace. Set-pixel, non-refreshing tick and ignored items finish at acceptance. A fill sweeps
// all 2^ADDR_W addresses (1024 here), one a cycle. After reset the same sweep clears the store, taking no item.
module led_matrix_bcm_scanner_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lmbs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lmbs_pkg::rsp_type rsp_data
);

   // Sequencer states. SWEEP writes one value to every address (reset clear
   // and fill), RUN issues one column read per cycle while the read stage can move on.
   typedef enum logic [2:0] {
      ST_SWEEP = 3'b001,
      ST_IDLE  = 3'b010,
      ST_RUN   = 3'b100
   } state_type;

   localparam logic [lmbs_pkg::ADDR_W-1:0] SWEEP_END = '1;
   localparam logic [lmbs_pkg::COL_W-1:0] LAST_COL =
      lmbs_pkg::COL_W'(lmbs_pkg::COLUMNS - 1);
   localparam logic [lmbs_pkg::SROW_W-1:0] LAST_ROW =
      lmbs_pkg::SROW_W'(lmbs_pkg::HALF_ROWS - 1);
   localparam logic [lmbs_pkg::PLANE_W-1:0] LAST_PLANE =
      lmbs_pkg::PLANE_W'(lmbs_pkg::PLANES - 1);

   state_type                       state_ff, state_in;
   logic [lmbs_pkg::ADDR_W-1:0]     sweep_addr_ff, sweep_addr_in;
   logic [lmbs_pkg::PIX_W-1:0]      sweep_value_ff, sweep_value_in;
   logic [lmbs_pkg::SROW_W-1:0]     scan_row_ff, scan_row_in;
   logic [lmbs_pkg::PLANE_W-1:0]    bit_plane_ff, bit_plane_in;
   logic [lmbs_pkg::DWELL_W-1:0]    dwell_ff, dwell_in;
   logic [lmbs_pkg::COL_W-1:0]      col_ff, col_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_last_ff, s1_last_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lmbs_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   lmbs_pkg::ram_ctl_type           ram_ctl;
   logic [lmbs_pkg::PIX_W-1:0]      rd_top;
   logic [lmbs_pkg::PIX_W-1:0]      rd_bot;

   logic                            accept;
   logic                            move;
   logic                            issue;
   logic [3:0]                      dwell_limit;
   logic                            x_ok;
   logic                            y_top;
   logic                            y_bot;
   logic [7:0]                      y_bot_row;
   logic [lmbs_pkg::ADDR_W-1:0]     set_addr;

   // The last word of a run formats its color and row select from the scan
   // state when it leaves the read stage, so a new item is only taken once
   // that stage is empty or emptying in the same cycle.
   assign req_ready = (state_ff == ST_IDLE) && (!s1_valid_ff || move);
   assign accept    = req_valid && req_ready;

   // The output register frees up when empty or taken this cycle; the read
   // stage moves into it then, and a new read may be issued whenever the
   // read stage is empty or moving on.
   assign move  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign issue = (state_ff == ST_RUN) && (!s1_valid_ff || move);

   // Dwell length of the current plane is 2^plane ticks.
   assign dwell_limit = (4'd1 << bit_plane_ff) - 4'd1;

   // Set-pixel range check and split into top and bottom half.
   assign x_ok      = (req_data.x < 8'(lmbs_pkg::COLUMNS));
   assign y_top     = (req_data.y < 8'(lmbs_pkg::HALF_ROWS));
   assign y_bot     = !y_top && (req_data.y < 8'(2 * lmbs_pkg::HALF_ROWS));
   assign y_bot_row = req_data.y - 8'(lmbs_pkg::HALF_ROWS);
   assign set_addr  = y_top
      ? {req_data.y[lmbs_pkg::ROW_W-1:0], req_data.x[lmbs_pkg::COL_W-1:0]}
      : {y_bot_row[lmbs_pkg::ROW_W-1:0], req_data.x[lmbs_pkg::COL_W-1:0]};

   always_comb begin
      state_in       = state_ff;
      sweep_addr_in  = sweep_addr_ff;
      sweep_value_in = sweep_value_ff;
      scan_row_in    = scan_row_ff;
      bit_plane_in   = bit_plane_ff;
      dwell_in       = dwell_ff;
      col_in         = col_ff;

      ram_ctl.wr_top  = 1'b0;
      ram_ctl.wr_bot  = 1'b0;
      ram_ctl.wr_addr = sweep_addr_ff;
      ram_ctl.wr_data = sweep_value_ff;
      ram_ctl.rd_en   = issue;
      ram_ctl.rd_addr = {scan_row_ff[lmbs_pkg::ROW_W-1:0], col_ff};

      unique case (state_ff)
         ST_SWEEP: begin
            ram_ctl.wr_top = 1'b1;
            ram_ctl.wr_bot = 1'b1;
            sweep_addr_in  = sweep_addr_ff + 1'b1;
            if (sweep_addr_ff == SWEEP_END) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.kind)
                  lmbs_pkg::KIND_SET: begin
                     ram_ctl.wr_top  = x_ok && y_top;
                     ram_ctl.wr_bot  = x_ok && y_bot;
                     ram_ctl.wr_addr = set_addr;
                     ram_ctl.wr_data = lmbs_pkg::pack_color(req_data.red,
                                                            req_data.green,
                                                            req_data.blue);
                  end
                  lmbs_pkg::KIND_FILL: begin
                     sweep_addr_in  = '0;
                     sweep_value_in = lmbs_pkg::pack_color(req_data.red,
                                                           req_data.green,
                                                           req_data.blue);
                     state_in       = ST_SWEEP;
                  end
                  lmbs_pkg::KIND_TICK: begin
                     if ({1'b0, dwell_ff} < dwell_limit) begin
                        dwell_in = dwell_ff + 1'b1;
                     end else begin
                        // Plane complete: step the plane, and after the last
                        // plane step the row, then refresh that row pair.
                        dwell_in = '0;
                        col_in   = '0;
                        state_in = ST_RUN;
                        if (bit_plane_ff >= LAST_PLANE) begin
                           bit_plane_in = '0;
                           scan_row_in  = (scan_row_ff >= LAST_ROW) ? '0
                                          : scan_row_ff + 1'b1;
                        end else begin
                           bit_plane_in = bit_plane_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (issue) begin
               col_in = col_ff + 1'b1;
               if (col_ff == LAST_COL) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Read stage and output register.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_last_in   = s1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.color_bits   = {lmbs_pkg::plane_bits(rd_bot, bit_plane_ff),
                                     lmbs_pkg::plane_bits(rd_top, bit_plane_ff)};
         rsp_data_in.row_select   = s1_last_ff ? scan_row_ff : '0;
         rsp_data_in.latch_strobe = s1_last_ff;
         rsp_data_in.last         = s1_last_ff;
         s1_valid_in              = 1'b0;
      end
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_last_in  = (col_ff == LAST_COL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_addr_ff  <= '0;
         sweep_value_ff <= '0;
         scan_row_ff    <= '0;
         bit_plane_ff   <= '0;
         dwell_ff       <= '0;
         col_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_addr_ff  <= sweep_addr_in;
         sweep_value_ff <= sweep_value_in;
         scan_row_ff    <= scan_row_in;
         bit_plane_ff   <= bit_plane_in;
         dwell_ff       <= dwell_in;
         col_ff         <= col_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   lmbs_frame_bank u_frame_bank (
      .clock  (clock),
      .ctl    (ram_ctl),
      .rd_top (rd_top),
      .rd_bot (rd_bot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- test/led_matrix_bcm_scanner_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix BCM scanner testbench
// Writes pixels and whole-screen fills, sends dwell ticks, and checks every column
// word of every refresh run against a scan predictor kept in step or a plan row.
// ----------------------------------------------------------------------------
module led_matrix_bcm_scanner_top_test;

   // Kind code that the block must ignore.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int CLK_PERIOD   = 4;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 210;
   localparam int IDLE_PERCENT = 8;

   // A fill or the clearing sweep after reset keeps the block away from the
   // input for one full pass over the store, so that pass sets the scale.
   localparam int SWEEP_CYCLES = (1 << lmbs_pkg::ADDR_W) + lmbs_pkg::COLUMNS + 8;
   localparam int STALL_LIMIT  = 4 * SWEEP_CYCLES;
   localparam int DRAIN_CYCLES = SWEEP_CYCLES;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lmbs_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lmbs_pkg::rsp_type rsp_data;

   always #(CLK_PERIOD / 2) clock = ~clock;

   led_matrix_bcm_scanner_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // One row of the directed plan. Where typed is set, every column word of
   // the resulting refresh run carries color, and the final word carries row.
   typedef struct {
      lmbs_pkg::req_type           item;
      bit                          typed;
      logic [5:0]                  color;
      logic [lmbs_pkg::SROW_W-1:0] row;
   } plan_step_type;

   plan_step_type scan_plan [$];

   // Column words still due from the block, oldest first.
   lmbs_pkg::rsp_type column_words_due [$];

   // Words of the refresh run that the latest item causes, if any.
   lmbs_pkg::rsp_type refresh_run [$];

   // Our own copy of the scanner state.
   logic [lmbs_pkg::PIX_W-1:0]   pixel_mem [lmbs_pkg::PANEL_ROWS * lmbs_pkg::COLUMNS];
   logic [lmbs_pkg::SROW_W-1:0]  row_now   = '0;
   logic [lmbs_pkg::PLANE_W-1:0] plane_now = '0;
   logic [lmbs_pkg::DWELL_W-1:0] dwell_now = '0;

   int mismatches    = 0;
   int words_checked = 0;
   int stall_cycles  = 0;
   int tick_count    = 0;
   int refresh_count = 0;
   int set_count     = 0;
   int fill_count    = 0;
   int ignored_count = 0;

   // While this is set neither side idles.
   bit steady_stretch = 1'b0;

   initial begin
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
   end

   task automatic note_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         note_mismatch($sformatf("column word %0d, %s: got %0d, expected %0d",
                                 words_checked, name, got, want));
      end
   endtask

   // Applies one accepted item to the predicted scanner state. A refreshing
   // tick leaves its column words in refresh_run.
   task automatic advance_scanner(input lmbs_pkg::req_type item);
      int                         target;
      int                         top_base;
      int                         bot_base;
      logic [lmbs_pkg::PIX_W-1:0] top_pix;
      logic [lmbs_pkg::PIX_W-1:0] bot_pix;
      logic [lmbs_pkg::PIX_W-1:0] color;
      lmbs_pkg::rsp_type          word;
      refresh_run.delete();
      color = {item.blue[3:0], item.green[3:0], item.red[3:0]};
      case (item.kind)
         lmbs_pkg::KIND_SET: begin
            set_count++;
            // Writes outside the panel are dropped.
            if (int'(item.x) < lmbs_pkg::COLUMNS && int'(item.y) < lmbs_pkg::PANEL_ROWS) begin
               pixel_mem[int'(item.y) * lmbs_pkg::COLUMNS + int'(item.x)] = color;
            end
         end
         lmbs_pkg::KIND_FILL: begin
            fill_count++;
            foreach (pixel_mem[i]) pixel_mem[i] = color;
         end
         lmbs_pkg::KIND_TICK: begin
            tick_count++;
            target = 1 << int'(plane_now);
            if (int'(dwell_now) < target - 1) begin
               // Still dwelling on this plane: no refresh yet.
               dwell_now = dwell_now + 1'b1;
            end else begin
               refresh_count++;
               dwell_now = '0;
               if (int'(plane_now) == lmbs_pkg::PLANES - 1) begin
                  plane_now = '0;
                  row_now   = lmbs_pkg::SROW_W'((int'(row_now) + 1) % lmbs_pkg::HALF_ROWS);
               end else begin
                  plane_now = plane_now + 1'b1;
               end
               top_base = int'(row_now) * lmbs_pkg::COLUMNS;
               bot_base = (int'(row_now) + lmbs_pkg::HALF_ROWS) * lmbs_pkg::COLUMNS;
               for (int col = 0; col < lmbs_pkg::COLUMNS; col++) begin
                  top_pix = pixel_mem[top_base + col];
                  bot_pix = pixel_mem[bot_base + col];
                  word.color_bits = {bot_pix[8 + plane_now], bot_pix[4 + plane_now],
                                     bot_pix[plane_now], top_pix[8 + plane_now],
                                     top_pix[4 + plane_now], top_pix[plane_now]};
                  word.latch_strobe = (col == lmbs_pkg::COLUMNS - 1);
                  word.last         = (col == lmbs_pkg::COLUMNS - 1);
                  word.row_select   = word.last ? row_now : '0;
                  refresh_run.push_back(word);
               end
            end
         end
         default: ignored_count++;
      endcase
   endtask

   task automatic add_step(input logic [1:0] kind, input logic [7:0] x,
                           input logic [7:0] y, input logic [7:0] red,
                           input logic [7:0] green, input logic [7:0] blue,
                           input bit typed, input logic [5:0] color,
                           input logic [lmbs_pkg::SROW_W-1:0] row);
      plan_step_type step;
      step.item  = '{kind: kind, x: x, y: y, red: red, green: green, blue: blue};
      step.typed = typed;
      step.color = color;
      step.row   = row;
      scan_plan.push_back(step);
   endtask

   // Offers one item, waits for the handshake and books what it should cause.
   // Called at a rising edge; returns at a rising edge.
   task automatic send_item(input lmbs_pkg::req_type item, input bit typed,
                            input logic [5:0] color,
                            input logic [lmbs_pkg::SROW_W-1:0] row);
      lmbs_pkg::rsp_type word;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && req_ready));
      advance_scanner(item);
      if (typed) begin
         // The predictor still runs to keep its state, but the words that
         // are due come from the plan row.
         for (int col = 0; col < lmbs_pkg::COLUMNS; col++) begin
            word.color_bits   = color;
            word.latch_strobe = (col == lmbs_pkg::COLUMNS - 1);
            word.last         = (col == lmbs_pkg::COLUMNS - 1);
            word.row_select   = word.last ? row : '0;
            column_words_due.push_back(word);
         end
      end else begin
         foreach (refresh_run[i]) column_words_due.push_back(refresh_run[i]);
      end
      // Sometimes hold back the next item.
      if (!steady_stretch && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // The result side stalls at random, except in the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady_stretch || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // Every accepted column word is compared with the oldest one due.
   always @(posedge clock) begin : word_check
      lmbs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (column_words_due.size() == 0) begin
            note_mismatch($sformatf("column word with none due: color_bits %0d row %0d",
                                    rsp_data.color_bits, rsp_data.row_select));
         end else begin
            want = column_words_due.pop_front();
            check_field("color_bits", 32'(rsp_data.color_bits), 32'(want.color_bits));
            check_field("row_select", 32'(rsp_data.row_select), 32'(want.row_select));
            check_field("latch_strobe", 32'(rsp_data.latch_strobe),
                        32'(want.latch_strobe));
            check_field("last", 32'(rsp_data.last), 32'(want.last));
         end
         words_checked++;
      end
   end

   // Watchdog: a long stretch with no handshake on either side means the
   // block has hung or a result never came.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles, %0d column words still due",
                  stall_cycles, column_words_due.size());
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int                pick;
      lmbs_pkg::req_type item;

      // Directed plan. The first tick after reset refreshes at once, against
      // a cleared store. After a fill with all ones every word is all ones.
      add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 6'd0, 4'd0);
      // Plane 1 needs two ticks, so this one only counts.
      add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 6'd63, 4'd0);
      // The unused kind with every field high must change nothing.
      add_step(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 6'd0, 4'd0);
      // Corner pixel, then writes just outside and far outside the panel.
      add_step(lmbs_pkg::KIND_SET, 8'd63, 8'd31, 8'hF0, 8'h0F, 8'h00, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_SET, 8'd64, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_SET, 8'd0, 8'd32, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_SET, 8'd255, 8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0, 4'd0);
      // Mixed nibbles in the top and bottom rows of the first row pair.
      add_step(lmbs_pkg::KIND_SET, 8'd0, 8'd0, 8'h05, 8'h0A, 8'hF3, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_SET, 8'd0, 8'd16, 8'hFA, 8'h05, 8'h0C, 1'b0, 6'd0, 4'd0);
      // Plane 2 dwells four ticks, plane 3 eight; the last one steps the row.
      repeat (4) begin
         add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      end
      repeat (8) begin
         add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 6'd0, 4'd0);
      end
      add_step(lmbs_pkg::KIND_FILL, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 1'b0, 6'd0, 4'd0);
      add_step(lmbs_pkg::KIND_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 6'd0, 4'd1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (scan_plan[i]) begin
         send_item(scan_plan[i].item, scan_plan[i].typed, scan_plan[i].color,
                   scan_plan[i].row);
      end

      // Random part: mostly ticks and in-panel writes aimed at the rows that
      // are about to be scanned, with a few fills, stray writes and unused
      // kinds mixed in.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady_stretch = (n >= 90 && n < 140);
         item.x     = 8'($urandom_range(0, 255));
         item.y     = 8'($urandom_range(0, 255));
         item.red   = 8'($urandom_range(0, 255));
         item.green = 8'($urandom_range(0, 255));
         item.blue  = 8'($urandom_range(0, 255));
         pick = int'($urandom_range(0, 99));
         if (pick < 62) begin
            item.kind = lmbs_pkg::KIND_TICK;
         end else if (pick < 88) begin
            item.kind = lmbs_pkg::KIND_SET;
            item.x    = 8'($urandom_range(0, lmbs_pkg::COLUMNS - 1));
            if ($urandom_range(0, 1) == 1) begin
               item.y = 8'((int'(row_now) + int'($urandom_range(0, 1)))
                           % lmbs_pkg::HALF_ROWS
                           + (($urandom_range(0, 1) == 1) ? lmbs_pkg::HALF_ROWS : 0));
            end else begin
               item.y = 8'($urandom_range(0, lmbs_pkg::PANEL_ROWS - 1));
            end
         end else if (pick < 92) begin
            item.kind = lmbs_pkg::KIND_FILL;
         end else if (pick < 96) begin
            // Stray write: any position, most of them off the panel.
            item.kind = lmbs_pkg::KIND_SET;
         end else begin
            item.kind = KIND_UNUSED;
         end
         send_item(item, 1'b0, 6'd0, '0);
      end
      steady_stretch = 1'b0;
      req_valid <= 1'b0;

      while (column_words_due.size() != 0) @(posedge clock);
      // A trailing fill or write may still be under way; give it time so
      // that any stray word it produced would be caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d ticks, %0d pixel writes, %0d fills and %0d ignored items.",
               tick_count, set_count, fill_count, ignored_count);
      $display("Checked %0d column words over %0d refresh runs, reaching scan row %0d.",
               words_checked, refresh_count, row_now);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
